FILE: sv/record_table_insertion_sort_ranker_core_assert.svh
// Assertion macros for the record table ranker.
`ifndef RECORD_TABLE_INSERTION_SORT_RANKER_CORE_ASSERT_SVH
`define RECORD_TABLE_INSERTION_SORT_RANKER_CORE_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define RTIS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rtis assertion failed");

// Condition that must hold in the cycle after a trigger.
`define RTIS_ASSERT_NEXT(lbl, trig, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error("rtis assertion failed");

`endif

FILE: sv/rtis_pkg.sv
// Shared types, codes and constants of the record table ranker.
package rtis_pkg;

    localparam int MAX_RECORDS_DEF = 64;
    localparam int NUM_COURSES_DEF = 10;

    // Fixed field widths (record count is at most 64, courses at most 16)
    localparam int POS_W    = 6;
    localparam int CNT_W    = 7;
    localparam int CRS_W    = 4;
    localparam int ID_W     = 32;
    localparam int SCORE_W  = 8;
    localparam int TOTAL_W  = 16;
    localparam int STATUS_W = 3;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_RANK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_CRS   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD,
        S_SS_A,
        S_SS_B,
        S_SS_C,
        S_SO_I,
        S_SO_IB,
        S_SO_IC,
        S_SO_J,
        S_SO_JB,
        S_SO_JC,
        S_SO_PUT,
        S_EM_A,
        S_EM_B,
        S_EM_C,
        S_RESP
    } state_t;

    // Memory port commands from the sequencer to the record store
    typedef struct packed {
        logic [POS_W-1:0]         ord_raddr;
        logic                     ord_we;
        logic [POS_W-1:0]         ord_waddr;
        logic [POS_W-1:0]         ord_wdata;
        logic [POS_W-1:0]         rec_raddr;
        logic [CRS_W-1:0]         sc_rcourse;
        logic                     id_we;
        logic                     tot_we;
        logic [POS_W-1:0]         rec_waddr;
        logic [ID_W-1:0]          id_wdata;
        logic [TOTAL_W-1:0]       tot_wdata;
        logic                     sc_we;
        logic [CRS_W-1:0]         sc_wcourse;
        logic [SCORE_W-1:0]       sc_wdata;
    } mem_cmd_t;

endpackage

FILE: sv/rtis_store.sv
// Record store: order table, ids, totals and course scores.
module rtis_store
    import rtis_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
)
(
    input  logic                clk,
    input  mem_cmd_t            cmd,
    output logic [POS_W-1:0]    ord_rdata,
    output logic [ID_W-1:0]     id_rdata,
    output logic [TOTAL_W-1:0]  tot_rdata,
    output logic [SCORE_W-1:0]  sc_rdata
);

    localparam int SW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int SC_DEPTH = MAX_RECORDS * (1 << CRS_W);

    logic [POS_W-1:0]   ord_mem [MAX_RECORDS];
    logic [ID_W-1:0]    id_mem  [MAX_RECORDS];
    logic [TOTAL_W-1:0] tot_mem [MAX_RECORDS];
    logic [SCORE_W-1:0] sc_mem  [SC_DEPTH];

    // Order table: position -> physical slot
    always_ff @(posedge clk)
    begin
        if (cmd.ord_we)
        begin
            ord_mem[cmd.ord_waddr[SW-1:0]] <= cmd.ord_wdata;
        end
        ord_rdata <= ord_mem[cmd.ord_raddr[SW-1:0]];
    end

    // Per-slot id and total
    always_ff @(posedge clk)
    begin
        if (cmd.id_we)
        begin
            id_mem[cmd.rec_waddr[SW-1:0]] <= cmd.id_wdata;
        end
        if (cmd.tot_we)
        begin
            tot_mem[cmd.rec_waddr[SW-1:0]] <= cmd.tot_wdata;
        end
        id_rdata  <= id_mem[cmd.rec_raddr[SW-1:0]];
        tot_rdata <= tot_mem[cmd.rec_raddr[SW-1:0]];
    end

    // Course scores, one row of 16 per slot
    always_ff @(posedge clk)
    begin
        if (cmd.sc_we)
        begin
            sc_mem[{cmd.rec_waddr[SW-1:0], cmd.sc_wcourse}] <= cmd.sc_wdata;
        end
        sc_rdata <= sc_mem[{cmd.rec_raddr[SW-1:0], cmd.sc_rcourse}];
    end

endmodule

FILE: sv/record_table_insertion_sort_ranker_core.sv
// Add: clears one course score per cycle over all NUM_COURSES courses, then sends the result word.
// Set-score: scans table positions for the id (states S_SS_A, S_SS_B, S_SS_C), then sends the result.
// Rank: insertion sort over an order table, then one emitted word per record;
// one read port per store memory.
// One item at a time; in_stall is high while an item is in work.
// Reset (rst_n, async low) clears the record count and control; the store is not cleared.
`include "record_table_insertion_sort_ranker_core_assert.svh"
module record_table_insertion_sort_ranker_core
    import rtis_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF,
    parameter int NUM_COURSES = NUM_COURSES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           op,
    input  logic [ID_W-1:0]      student_id,
    input  logic [CRS_W-1:0]     course,
    input  logic [SCORE_W-1:0]   score,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [STATUS_W-1:0]  status,
    output logic [6:0]           rank,
    output logic [ID_W-1:0]      record_id,
    output logic [TOTAL_W-1:0]   key_value,
    output logic                 last
);

    localparam logic [CNT_W-1:0]   MAX_C = CNT_W'(MAX_RECORDS);
    localparam logic [CRS_W:0]     NC_C  = (CRS_W+1)'(NUM_COURSES);

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [CRS_W-1:0]      course_reg, course_next;
    logic [SCORE_W-1:0]    score_reg, score_next;
    logic [CNT_W-1:0]      p_reg, p_next;
    logic [CNT_W-1:0]      j_reg, j_next;
    logic [POS_W-1:0]      tmp_slot_reg, tmp_slot_next;
    logic [POS_W-1:0]      slot_reg, slot_next;
    logic [TOTAL_W-1:0]    tkey_reg, tkey_next;
    logic [CRS_W-1:0]      cc_reg, cc_next;
    logic [STATUS_W-1:0]   rsp_status_reg, rsp_status_next;
    logic [ID_W-1:0]       rsp_id_reg, rsp_id_next;
    logic [TOTAL_W-1:0]    rsp_key_reg, rsp_key_next;

    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [6:0]            rank_reg, rank_next;
    logic [ID_W-1:0]       rid_reg, rid_next;
    logic [TOTAL_W-1:0]    key_reg, key_next;
    logic                  last_reg, last_next;

    mem_cmd_t              cmd;
    logic [POS_W-1:0]      ord_rdata;
    logic [ID_W-1:0]       id_rdata;
    logic [TOTAL_W-1:0]    tot_rdata;
    logic [SCORE_W-1:0]    sc_rdata;

    logic                  out_free;
    logic                  by_total;
    logic [TOTAL_W-1:0]    rd_key;
    logic [TOTAL_W:0]      sum;
    logic [TOTAL_W-1:0]    sat_total;

    rtis_store #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_store (
        .clk       (clk),
        .cmd       (cmd),
        .ord_rdata (ord_rdata),
        .id_rdata  (id_rdata),
        .tot_rdata (tot_rdata),
        .sc_rdata  (sc_rdata)
    );

    // Key and saturating total from store read data
    assign out_free  = !out_valid_reg || !out_stall;
    assign by_total  = !({1'b0, course_reg} < NC_C);
    assign rd_key    = by_total ? tot_rdata : {{(TOTAL_W-SCORE_W){1'b0}}, sc_rdata};
    assign sum       = {1'b0, tot_rdata} + {{(TOTAL_W+1-SCORE_W){1'b0}}, score_reg};
    assign sat_total = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and output payload registers
    always_ff @(posedge clk)
    begin
        id_reg         <= id_next;
        course_reg     <= course_next;
        score_reg      <= score_next;
        p_reg          <= p_next;
        j_reg          <= j_next;
        tmp_slot_reg   <= tmp_slot_next;
        slot_reg       <= slot_next;
        tkey_reg       <= tkey_next;
        cc_reg         <= cc_next;
        rsp_status_reg <= rsp_status_next;
        rsp_id_reg     <= rsp_id_next;
        rsp_key_reg    <= rsp_key_next;
        status_reg     <= status_next;
        rank_reg       <= rank_next;
        rid_reg        <= rid_next;
        key_reg        <= key_next;
        last_reg       <= last_next;
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        id_next         = id_reg;
        course_next     = course_reg;
        score_next      = score_reg;
        p_next          = p_reg;
        j_next          = j_reg;
        tmp_slot_next   = tmp_slot_reg;
        slot_next       = slot_reg;
        tkey_next       = tkey_reg;
        cc_next         = cc_reg;
        rsp_status_next = rsp_status_reg;
        rsp_id_next     = rsp_id_reg;
        rsp_key_next    = rsp_key_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        rank_next       = rank_reg;
        rid_next        = rid_reg;
        key_next        = key_reg;
        last_next       = last_reg;

        cmd             = '0;
        cmd.ord_raddr   = p_reg[POS_W-1:0];
        cmd.rec_raddr   = slot_reg;
        cmd.sc_rcourse  = course_reg;
        cmd.rec_waddr   = slot_reg;
        cmd.sc_wcourse  = course_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    id_next      = student_id;
                    course_next  = course;
                    score_next   = score;
                    p_next       = '0;
                    cc_next      = '0;
                    rsp_id_next  = student_id;
                    rsp_key_next = '0;
                    case (op)
                        OP_ADD:
                        begin
                            if (cnt_reg >= MAX_C)
                            begin
                                rsp_status_next = ST_FULL;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                state_next = S_ADD;
                            end
                        end
                        OP_SET:
                        begin
                            if (cnt_reg == '0)
                            begin
                                rsp_status_next = ST_UNKNOWN;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SS_A;
                            end
                        end
                        OP_RANK:
                        begin
                            rsp_id_next = '0;
                            if ({1'b0, course} > NC_C)
                            begin
                                rsp_status_next = ST_BAD_CRS;
                                state_next      = S_RESP;
                            end
                            else if (cnt_reg == '0)
                            begin
                                rsp_status_next = ST_EMPTY;
                                state_next      = S_RESP;
                            end
                            else if (cnt_reg == CNT_W'(1))
                            begin
                                state_next = S_EM_A;
                            end
                            else
                            begin
                                p_next     = CNT_W'(1);
                                state_next = S_SO_I;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Append: order entry, id and total once, while the score row is cleared course by course
            S_ADD:
            begin
                cmd.rec_waddr  = cnt_reg[POS_W-1:0];
                cmd.sc_we      = 1'b1;
                cmd.sc_wcourse = cc_reg;
                cmd.sc_wdata   = '0;
                if (cc_reg == '0)
                begin
                    cmd.ord_we    = 1'b1;
                    cmd.ord_waddr = cnt_reg[POS_W-1:0];
                    cmd.ord_wdata = cnt_reg[POS_W-1:0];
                    cmd.id_we     = 1'b1;
                    cmd.id_wdata  = id_reg;
                    cmd.tot_we    = 1'b1;
                    cmd.tot_wdata = '0;
                end
                cc_next = cc_reg + 1'b1;
                if ({1'b0, cc_reg} == NC_C - 1'b1)
                begin
                    cnt_next        = cnt_reg + 1'b1;
                    rsp_status_next = ST_OK;
                    state_next      = S_RESP;
                end
            end

            // Id search in stored order
            S_SS_A:
            begin
                state_next = S_SS_B;
            end
            S_SS_B:
            begin
                cmd.rec_raddr = ord_rdata;
                slot_next     = ord_rdata;
                state_next    = S_SS_C;
            end
            S_SS_C:
            begin
                if (id_rdata == id_reg)
                begin
                    if (!({1'b0, course_reg} < NC_C))
                    begin
                        rsp_status_next = ST_BAD_CRS;
                    end
                    else
                    begin
                        cmd.sc_we       = 1'b1;
                        cmd.sc_wdata    = score_reg;
                        cmd.tot_we      = 1'b1;
                        cmd.tot_wdata   = sat_total;
                        rsp_status_next = ST_OK;
                        rsp_key_next    = sat_total;
                    end
                    state_next = S_RESP;
                end
                else if (p_reg + 1'b1 == cnt_reg)
                begin
                    rsp_status_next = ST_UNKNOWN;
                    state_next      = S_RESP;
                end
                else
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = S_SS_A;
                end
            end

            // Insertion sort: fetch the record at position i
            S_SO_I:
            begin
                state_next = S_SO_IB;
            end
            S_SO_IB:
            begin
                cmd.rec_raddr = ord_rdata;
                tmp_slot_next = ord_rdata;
                j_next        = p_reg;
                state_next    = S_SO_IC;
            end
            S_SO_IC:
            begin
                tkey_next  = rd_key;
                state_next = S_SO_J;
            end
            // Compare with the record at position j-1
            S_SO_J:
            begin
                cmd.ord_raddr = POS_W'(j_reg - 1'b1);
                if (j_reg == '0)
                begin
                    state_next = S_SO_PUT;
                end
                else
                begin
                    state_next = S_SO_JB;
                end
            end
            S_SO_JB:
            begin
                cmd.rec_raddr = ord_rdata;
                slot_next     = ord_rdata;
                state_next    = S_SO_JC;
            end
            S_SO_JC:
            begin
                if (rd_key > tkey_reg)
                begin
                    cmd.ord_we    = 1'b1;
                    cmd.ord_waddr = j_reg[POS_W-1:0];
                    cmd.ord_wdata = slot_reg;
                    j_next        = j_reg - 1'b1;
                    state_next    = S_SO_J;
                end
                else
                begin
                    state_next = S_SO_PUT;
                end
            end
            S_SO_PUT:
            begin
                cmd.ord_we    = 1'b1;
                cmd.ord_waddr = j_reg[POS_W-1:0];
                cmd.ord_wdata = tmp_slot_reg;
                if (p_reg + 1'b1 == cnt_reg)
                begin
                    p_next     = cnt_reg - 1'b1;
                    state_next = S_EM_A;
                end
                else
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = S_SO_I;
                end
            end

            // Emit from the top position down
            S_EM_A:
            begin
                state_next = S_EM_B;
            end
            S_EM_B:
            begin
                cmd.rec_raddr = ord_rdata;
                slot_next     = ord_rdata;
                state_next    = S_EM_C;
            end
            S_EM_C:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    rank_next      = 7'(cnt_reg - p_reg);
                    rid_next       = id_rdata;
                    key_next       = rd_key;
                    last_next      = (p_reg == '0);
                    if (p_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        p_next     = p_reg - 1'b1;
                        state_next = S_EM_A;
                    end
                end
            end

            // Single-word result
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = rsp_status_reg;
                    rank_next      = '0;
                    rid_next       = rsp_id_reg;
                    key_next       = rsp_key_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign rank      = rank_reg;
    assign record_id = rid_reg;
    assign key_value = key_reg;
    assign last      = last_reg;

    // Checks
    `RTIS_ASSERT(a_cnt_bound, cnt_reg <= MAX_C)
    `RTIS_ASSERT_NEXT(a_cnt_mono, 1'b1, cnt_reg >= $past(cnt_reg))
    `RTIS_ASSERT(a_rank_ok, out_valid_reg |-> (rank_reg == '0 || status_reg == ST_OK))
    `RTIS_ASSERT(a_rank_range, out_valid_reg |-> (7'(cnt_reg) >= rank_reg))

endmodule

FILE: test/record_table_ranker_checker.sv
// Checker for the record table ranker: predicts result words and compares them.
`timescale 1ns / 1ps
module record_table_ranker_checker
    import rtis_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [1:0]          op,
    input  logic [ID_W-1:0]     student_id,
    input  logic [CRS_W-1:0]    course,
    input  logic [SCORE_W-1:0]  score,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [STATUS_W-1:0] status,
    input  logic [6:0]          rank,
    input  logic [ID_W-1:0]     record_id,
    input  logic [TOTAL_W-1:0]  key_value,
    input  logic                last,
    output int                  mismatches,
    output int                  words_pending,
    output int                  words_checked
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [6:0]          rank;
        logic [ID_W-1:0]     record_id;
        logic [TOTAL_W-1:0]  key_value;
        logic                last;
    } result_word_t;

    // Shadow copy of the record store
    logic [ID_W-1:0]    shadow_ids    [MAX_RECORDS_DEF];
    logic [SCORE_W-1:0] shadow_scores [MAX_RECORDS_DEF][NUM_COURSES_DEF];
    logic [TOTAL_W-1:0] shadow_totals [MAX_RECORDS_DEF];
    int                 shadow_count;

    result_word_t expected_words[$];

    function automatic logic [TOTAL_W-1:0] sort_key(int r, int c);
        if (c >= NUM_COURSES_DEF)
            return shadow_totals[r];
        return {8'd0, shadow_scores[r][c]};
    endfunction

    function automatic result_word_t make_word(logic [STATUS_W-1:0] st, int rk,
                                               logic [ID_W-1:0] id,
                                               logic [TOTAL_W-1:0] key, bit lst);
        result_word_t w;
        w.status = st;
        w.rank = rk[6:0];
        w.record_id = id;
        w.key_value = key;
        w.last = lst;
        return w;
    endfunction

    // Apply one accepted input word to the shadow store and queue its results
    task automatic predict_ranking(logic [1:0] o, logic [ID_W-1:0] id, int c,
                                   logic [SCORE_W-1:0] sc);
        int i;
        int j;
        int hit;
        int sum;
        logic [ID_W-1:0]    tid;
        logic [TOTAL_W-1:0] ttot;
        logic [SCORE_W-1:0] trow [NUM_COURSES_DEF];
        case (o)
            OP_ADD: begin
                if (shadow_count >= MAX_RECORDS_DEF)
                    expected_words.push_back(make_word(ST_FULL, 0, id, '0, 1'b1));
                else
                begin
                    shadow_ids[shadow_count] = id;
                    shadow_totals[shadow_count] = '0;
                    for (i = 0; i < NUM_COURSES_DEF; i++)
                        shadow_scores[shadow_count][i] = '0;
                    shadow_count++;
                    expected_words.push_back(make_word(ST_OK, 0, id, '0, 1'b1));
                end
            end
            OP_SET: begin
                hit = -1;
                for (i = 0; i < shadow_count && hit < 0; i++)
                    if (shadow_ids[i] == id)
                        hit = i;
                if (hit < 0)
                    expected_words.push_back(make_word(ST_UNKNOWN, 0, id, '0, 1'b1));
                else if (c >= NUM_COURSES_DEF)
                    expected_words.push_back(make_word(ST_BAD_CRS, 0, id, '0, 1'b1));
                else
                begin
                    shadow_scores[hit][c] = sc;
                    sum = shadow_totals[hit] + sc;
                    if (sum > 65535)
                        sum = 65535;
                    shadow_totals[hit] = sum[TOTAL_W-1:0];
                    expected_words.push_back(make_word(ST_OK, 0, id, shadow_totals[hit],
                                                       1'b1));
                end
            end
            OP_RANK: begin
                if (c > NUM_COURSES_DEF)
                    expected_words.push_back(make_word(ST_BAD_CRS, 0, '0, '0, 1'b1));
                else if (shadow_count == 0)
                    expected_words.push_back(make_word(ST_EMPTY, 0, '0, '0, 1'b1));
                else
                begin
                    // stable ascending insertion sort, swapping whole records
                    for (i = 1; i < shadow_count; i++)
                    begin
                        j = i;
                        while (j > 0 && sort_key(j - 1, c) > sort_key(j, c))
                        begin
                            tid = shadow_ids[j-1];
                            ttot = shadow_totals[j-1];
                            trow = shadow_scores[j-1];
                            shadow_ids[j-1] = shadow_ids[j];
                            shadow_totals[j-1] = shadow_totals[j];
                            shadow_scores[j-1] = shadow_scores[j];
                            shadow_ids[j] = tid;
                            shadow_totals[j] = ttot;
                            shadow_scores[j] = trow;
                            j--;
                        end
                    end
                    // emitted from the top of the table down
                    for (i = 0; i < shadow_count; i++)
                        expected_words.push_back(make_word(ST_OK, i + 1,
                            shadow_ids[shadow_count-1-i], sort_key(shadow_count-1-i, c),
                            i + 1 == shadow_count));
                end
            end
            default: ;
        endcase
    endtask

    assign words_pending = expected_words.size();

    // Watch both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        result_word_t got;
        result_word_t want;
        if (!rst_n)
        begin
            shadow_count = 0;
            mismatches <= 0;
            words_checked <= 0;
            expected_words.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = make_word(status, rank, record_id, key_value, last);
                words_checked <= words_checked + 1;
                if (expected_words.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result word %p", $realtime, got);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                            $display("%0t: result mismatch, expected %p, got %p",
                                     $realtime, want, got);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_ranking(op, student_id, course, score);
        end
    end

endmodule

FILE: test/tb_record_table_insertion_sort_ranker_core.sv
// Testbench top for the record table ranker: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module tb_record_table_insertion_sort_ranker_core;
    import rtis_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          op;
    logic [ID_W-1:0]     student_id;
    logic [CRS_W-1:0]    course;
    logic [SCORE_W-1:0]  score;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic [6:0]          rank;
    logic [ID_W-1:0]     record_id;
    logic [TOTAL_W-1:0]  key_value;
    logic                last;

    int mismatches;
    int words_pending;
    int words_checked;
    int cycle_count;
    int words_sent;
    int adds_sent;
    int burst_left;
    logic [ID_W-1:0] known_ids[$];

    record_table_insertion_sort_ranker_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .student_id(student_id), .course(course), .score(score),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .rank(rank), .record_id(record_id),
        .key_value(key_value), .last(last)
    );

    record_table_ranker_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .student_id(student_id), .course(course), .score(score),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .rank(rank), .record_id(record_id),
        .key_value(key_value), .last(last),
        .mismatches(mismatches), .words_pending(words_pending),
        .words_checked(words_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Receiver: random stall pattern, one long hold-off, and quiet stretches
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        repeat (3000) @(negedge clk)
            out_stall = ($urandom_range(0, 3) == 0);
        out_stall = 1'b1;
        for (hold = 0; hold < 600; hold++)
            @(negedge clk);
        forever
        begin
            repeat ($urandom_range(50, 400)) @(negedge clk)
                out_stall = ($urandom_range(0, 2) == 0);
            repeat ($urandom_range(20, 200)) @(negedge clk)
                out_stall = 1'b0;
        end
    end

    // Offer one word and hold it until accepted; gaps come between bursts
    task automatic send_word(logic [1:0] o, logic [ID_W-1:0] id, logic [CRS_W-1:0] c,
                             logic [SCORE_W-1:0] s);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            repeat ($urandom_range(0, 8)) @(negedge clk);
        end
        burst_left--;
        in_valid = 1'b1;
        op = o;
        student_id = id;
        course = c;
        score = s;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        in_valid = 1'b0;
        words_sent++;
        if (o == OP_ADD)
        begin
            adds_sent++;
            known_ids.push_back(id);
        end
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        if (known_ids.size() > 0 && $urandom_range(0, 9) < 8)
            return known_ids[$urandom_range(0, known_ids.size() - 1)];
        return $urandom;
    endfunction

    initial
    begin
        int i;
        int pick;
        logic [ID_W-1:0] id;
        logic [CRS_W-1:0] crs;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_ADD;
        student_id = '0;
        course = '0;
        score = '0;
        words_sent = 0;
        adds_sent = 0;
        burst_left = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty table, bad course, extremes, duplicates, unused op
        send_word(OP_RANK, 32'h1234_5678, CRS_W'(NUM_COURSES_DEF), 8'd0);
        send_word(OP_RANK, 32'd0, 4'd11, 8'd0);
        send_word(OP_RANK, 32'd0, 4'd15, 8'd0);
        send_word(OP_SET, 32'hDEAD_BEEF, 4'd15, 8'd9);
        send_word(OP_ADD, 32'h0000_0000, 4'd0, 8'd0);
        send_word(OP_ADD, 32'hFFFF_FFFF, 4'd15, 8'hFF);
        send_word(OP_ADD, 32'h0000_0000, 4'd3, 8'd7);
        send_word(OP_ADD, 32'hA5A5_5A5A, 4'd1, 8'd1);
        send_word(OP_SET, 32'hFFFF_FFFF, 4'd0, 8'hFF);
        send_word(OP_SET, 32'hFFFF_FFFF, 4'd9, 8'd0);
        send_word(OP_SET, 32'h0000_0000, 4'd9, 8'd200);
        send_word(OP_SET, 32'h0000_0000, 4'd10, 8'd5);
        send_word(OP_SET, 32'hA5A5_5A5A, 4'd15, 8'd5);
        send_word(OP_SET, 32'h5A5A_A5A5, 4'd2, 8'd5);
        send_word(OP_SET, 32'hA5A5_5A5A, 4'd0, 8'hFF);
        send_word(OP_UNUSED, 32'hFFFF_FFFF, 4'd15, 8'hFF);
        send_word(OP_RANK, 32'd0, 4'd0, 8'd0);
        send_word(OP_RANK, 32'd0, 4'd9, 8'd0);
        send_word(OP_RANK, 32'hFFFF_FFFF, CRS_W'(NUM_COURSES_DEF), 8'hFF);

        // Drive one total into saturation
        for (i = 0; i < 260; i++)
            send_word(OP_SET, 32'hFFFF_FFFF, CRS_W'(i % NUM_COURSES_DEF), 8'hFF);
        send_word(OP_RANK, 32'd0, CRS_W'(NUM_COURSES_DEF), 8'd0);

        // Random mix
        for (i = 0; i < 20; i++)
        begin
            pick = $urandom_range(0, 99);
            id = pick_id();
            if (pick < 30)
                send_word(OP_ADD, ($urandom_range(0, 4) == 0) ? id : $urandom,
                          CRS_W'($urandom), SCORE_W'($urandom));
            else if (pick < 80)
            begin
                crs = ($urandom_range(0, 9) == 0) ? CRS_W'($urandom)
                      : CRS_W'($urandom_range(0, NUM_COURSES_DEF - 1));
                send_word(OP_SET, id, crs, SCORE_W'($urandom));
            end
            else if (pick < 93)
            begin
                crs = ($urandom_range(0, 9) == 0) ? CRS_W'($urandom)
                      : CRS_W'($urandom_range(0, NUM_COURSES_DEF));
                send_word(OP_RANK, $urandom, crs, SCORE_W'($urandom));
            end
            else
                send_word(OP_UNUSED, $urandom, CRS_W'($urandom), SCORE_W'($urandom));
        end

        // Fill the table past its capacity, then score and rank the full table
        while (adds_sent < MAX_RECORDS_DEF + 2)
            send_word(OP_ADD, $urandom, CRS_W'($urandom), SCORE_W'($urandom));
        for (i = 0; i < 5; i++)
            send_word(OP_SET, pick_id(), CRS_W'($urandom_range(0, NUM_COURSES_DEF - 1)),
                      SCORE_W'($urandom));
        send_word(OP_RANK, 32'd0, CRS_W'($urandom_range(0, NUM_COURSES_DEF - 1)), 8'd0);
        send_word(OP_RANK, 32'd0, CRS_W'(NUM_COURSES_DEF), 8'd0);

        // Drain, then allow trailing cycles
        while (words_pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("sent %0d input words, checked %0d result words", words_sent,
                 words_checked);
        $display("covered adds up to a full table, score sets with saturation, all ranks");
        if (mismatches == 0 && words_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/rtis_pkg.sv
sv/rtis_store.sv
sv/record_table_insertion_sort_ranker_core.sv
test/record_table_ranker_checker.sv
test/tb_record_table_insertion_sort_ranker_core.sv
